// ----- hw/rtl/sic_pkg.sv -----
// Shared types, constants and operand tables for the segment intersection classifier.
`default_nettype none

package sic_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int EPS_BITS       = 32;
  localparam logic [EPS_BITS-1:0] EPS_RESET = 32'd1;

  typedef enum logic [1:0] {
    VERDICT_NONE  = 2'd0,
    VERDICT_CROSS = 2'd1,
    VERDICT_DEGEN = 2'd2
  } verdict_t;

  typedef struct packed {
    logic valid;
    logic shared;
  } sic_ctl_t;

  // Coordinate differences.
  localparam int D_ABX = 0;
  localparam int D_ABY = 1;
  localparam int D_ACX = 2;
  localparam int D_ACY = 3;
  localparam int D_ADX = 4;
  localparam int D_ADY = 5;
  localparam int D_DBX = 6;
  localparam int D_DBY = 7;
  localparam int D_BCX = 8;
  localparam int D_BCY = 9;
  localparam int D_CAX = 10;
  localparam int D_CAY = 11;
  localparam int NDIFF = 12;

  // Products of two differences.
  localparam int P_AB2X = 0;
  localparam int P_AB2Y = 1;
  localparam int P_ACX  = 2;
  localparam int P_ACY  = 3;
  localparam int P_ADX  = 4;
  localparam int P_ADY  = 5;
  localparam int P_CRC0 = 6;
  localparam int P_CRC1 = 7;
  localparam int P_CRD0 = 8;
  localparam int P_CRD1 = 9;
  localparam int P_T0A  = 10;
  localparam int NTURN  = 4;
  localparam int NPROD  = 18;

  localparam int PROD_L [NPROD] = '{
    D_ABX, D_ABY, D_ABX, D_ABY, D_ABX, D_ABY, D_ABX, D_ABY, D_ABX, D_ABY,
    D_ADX, D_ADY, D_DBX, D_DBY, D_BCX, D_BCY, D_CAX, D_CAY
  };
  localparam int PROD_R [NPROD] = '{
    D_ABX, D_ABY, D_ACX, D_ACY, D_ADX, D_ADY, D_ACY, D_ACX, D_ADY, D_ADX,
    D_DBY, D_DBX, D_BCY, D_BCX, D_CAY, D_CAX, D_ADY, D_ADX
  };

  // Width that holds every sum of two products and a product plus epsilon.
  function automatic int wide_bits(int cb);
    int w;
    w = 2 * cb + 4;
    if (w < EPS_BITS + 3) begin
      w = EPS_BITS + 3;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sic_diff_stage.sv -----
// First stage: coordinate differences and the shared endpoint check.
`default_nettype none

module sic_diff_stage import sic_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         take_i,
  input  wire logic signed [COORD_BITS-1:0] a_x_i,
  input  wire logic signed [COORD_BITS-1:0] a_y_i,
  input  wire logic signed [COORD_BITS-1:0] b_x_i,
  input  wire logic signed [COORD_BITS-1:0] b_y_i,
  input  wire logic signed [COORD_BITS-1:0] c_x_i,
  input  wire logic signed [COORD_BITS-1:0] c_y_i,
  input  wire logic signed [COORD_BITS-1:0] d_x_i,
  input  wire logic signed [COORD_BITS-1:0] d_y_i,
  output sic_ctl_t                          ctl_o,
  output logic signed [COORD_BITS:0]        diff_o [NDIFF]
);

  logic signed [COORD_BITS:0] ax, ay, bx, by, cx, cy, dx, dy;
  logic signed [COORD_BITS:0] diff_nxt [NDIFF];
  logic signed [COORD_BITS:0] diff_r   [NDIFF];
  sic_ctl_t                   ctl_nxt, ctl_r;

  assign ax = {a_x_i[COORD_BITS-1], a_x_i};
  assign ay = {a_y_i[COORD_BITS-1], a_y_i};
  assign bx = {b_x_i[COORD_BITS-1], b_x_i};
  assign by = {b_y_i[COORD_BITS-1], b_y_i};
  assign cx = {c_x_i[COORD_BITS-1], c_x_i};
  assign cy = {c_y_i[COORD_BITS-1], c_y_i};
  assign dx = {d_x_i[COORD_BITS-1], d_x_i};
  assign dy = {d_y_i[COORD_BITS-1], d_y_i};

  always_comb begin
    diff_nxt[D_ABX] = bx - ax;
    diff_nxt[D_ABY] = by - ay;
    diff_nxt[D_ACX] = cx - ax;
    diff_nxt[D_ACY] = cy - ay;
    diff_nxt[D_ADX] = dx - ax;
    diff_nxt[D_ADY] = dy - ay;
    diff_nxt[D_DBX] = bx - dx;
    diff_nxt[D_DBY] = by - dy;
    diff_nxt[D_BCX] = cx - bx;
    diff_nxt[D_BCY] = cy - by;
    diff_nxt[D_CAX] = ax - cx;
    diff_nxt[D_CAY] = ay - cy;
    ctl_nxt.valid  = take_i;
    ctl_nxt.shared = (ax == cx && ay == cy) || (bx == cx && by == cy) ||
                     (ax == dx && ay == dy) || (bx == dx && by == dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
  end

  assign ctl_o  = ctl_r;
  assign diff_o = diff_r;

endmodule

`default_nettype wire

// ----- hw/rtl/sic_mult_stage.sv -----
// Second stage: all products of coordinate differences, one multiplier each.
`default_nettype none

module sic_mult_stage import sic_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sic_ctl_t                     ctl_i,
  input  wire logic signed [COORD_BITS:0]   diff_i [NDIFF],
  output sic_ctl_t                          ctl_o,
  output logic signed [2*COORD_BITS+1:0]    prod_o [NPROD]
);

  localparam int PW = 2 * COORD_BITS + 2;

  logic signed [PW-1:0] prod_nxt [NPROD];
  logic signed [PW-1:0] prod_r   [NPROD];
  sic_ctl_t             ctl_r;

  for (genvar g = 0; g < NPROD; g++) begin : g_mul
    assign prod_nxt[g] = PW'(diff_i[PROD_L[g]]) * PW'(diff_i[PROD_R[g]]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign ctl_o  = ctl_r;
  assign prod_o = prod_r;

endmodule

`default_nettype wire

// ----- hw/rtl/sic_sum_stage.sv -----
// Third stage: dot and cross sums, projection upper bound and the turn sign test.
`default_nettype none

module sic_sum_stage import sic_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire sic_ctl_t                                ctl_i,
  input  wire logic signed [2*COORD_BITS+1:0]          prod_i [NPROD],
  input  wire logic        [EPS_BITS-1:0]              eps_i,
  output sic_ctl_t                                     ctl_o,
  output logic                                         turn_same_o,
  output logic signed [wide_bits(COORD_BITS)-1:0]      abac_o,
  output logic signed [wide_bits(COORD_BITS)-1:0]      abad_o,
  output logic signed [wide_bits(COORD_BITS)-1:0]      crc_o,
  output logic signed [wide_bits(COORD_BITS)-1:0]      crd_o,
  output logic signed [wide_bits(COORD_BITS)-1:0]      upper_o
);

  localparam int WW = wide_bits(COORD_BITS);

  logic signed [WW-1:0] pw [NPROD];
  logic signed [WW-1:0] eps_w;
  logic signed [WW-1:0] abac_nxt, abad_nxt, crc_nxt, crd_nxt, upper_nxt;
  logic signed [WW-1:0] abac_r, abad_r, crc_r, crd_r, upper_r;
  logic [NTURN-1:0]     t_neg, t_nz;
  logic                 turn_same_nxt, turn_same_r;
  sic_ctl_t             ctl_r;

  for (genvar g = 0; g < NPROD; g++) begin : g_ext
    assign pw[g] = WW'(prod_i[g]);
  end

  // The sign of a turn is the order of its two products, so no subtraction is needed.
  for (genvar t = 0; t < NTURN; t++) begin : g_turn
    assign t_neg[t] = prod_i[P_T0A + 2 * t] < prod_i[P_T0A + 2 * t + 1];
    assign t_nz[t]  = prod_i[P_T0A + 2 * t] != prod_i[P_T0A + 2 * t + 1];
  end

  assign eps_w = $signed({{(WW - EPS_BITS){1'b0}}, eps_i});

  always_comb begin
    abac_nxt      = pw[P_ACX] + pw[P_ACY];
    abad_nxt      = pw[P_ADX] + pw[P_ADY];
    crc_nxt       = pw[P_CRC0] - pw[P_CRC1];
    crd_nxt       = pw[P_CRD0] - pw[P_CRD1];
    upper_nxt     = pw[P_AB2X] + pw[P_AB2Y] + eps_w;
    turn_same_nxt = (&t_nz) && ((&t_neg) || !(|t_neg));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    abac_r      <= abac_nxt;
    abad_r      <= abad_nxt;
    crc_r       <= crc_nxt;
    crd_r       <= crd_nxt;
    upper_r     <= upper_nxt;
    turn_same_r <= turn_same_nxt;
  end

  assign ctl_o       = ctl_r;
  assign turn_same_o = turn_same_r;
  assign abac_o      = abac_r;
  assign abad_o      = abad_r;
  assign crc_o       = crc_r;
  assign crd_o       = crd_r;
  assign upper_o     = upper_r;

endmodule

`default_nettype wire

// ----- hw/rtl/sic_decide_stage.sv -----
// Last stage: epsilon compares, verdict selection and the result register.
`default_nettype none

module sic_decide_stage import sic_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire sic_ctl_t                                ctl_i,
  input  wire logic                                    turn_same_i,
  input  wire logic signed [wide_bits(COORD_BITS)-1:0] abac_i,
  input  wire logic signed [wide_bits(COORD_BITS)-1:0] abad_i,
  input  wire logic signed [wide_bits(COORD_BITS)-1:0] crc_i,
  input  wire logic signed [wide_bits(COORD_BITS)-1:0] crd_i,
  input  wire logic signed [wide_bits(COORD_BITS)-1:0] upper_i,
  input  wire logic        [EPS_BITS-1:0]              eps_i,
  output logic                                         strobe_o,
  output logic             [1:0]                       verdict_o
);

  localparam int WW = wide_bits(COORD_BITS);

  logic signed [WW-1:0] eps_w, neg_eps;
  logic                 cl_c, cl_d, c_below, c_above, d_below, d_above;
  verdict_t             verdict_nxt, verdict_r;
  logic                 strobe_r;

  assign eps_w   = $signed({{(WW - EPS_BITS){1'b0}}, eps_i});
  assign neg_eps = -eps_w;

  always_comb begin
    cl_c    = (neg_eps < crc_i) && (crc_i < eps_w);
    cl_d    = (neg_eps < crd_i) && (crd_i < eps_w);
    c_below = abac_i < upper_i;
    c_above = neg_eps < abac_i;
    d_below = abad_i < upper_i;
    d_above = neg_eps < abad_i;
    if (ctl_i.shared) begin
      verdict_nxt = VERDICT_DEGEN;
    end else if (cl_c && cl_d) begin
      // Overlap of the two projections: smaller one below the bound, larger one above.
      verdict_nxt = ((c_below || d_below) && (c_above || d_above)) ?
                    VERDICT_DEGEN : VERDICT_NONE;
    end else if (cl_c && c_below && c_above) begin
      verdict_nxt = VERDICT_DEGEN;
    end else if (!cl_c && cl_d && d_below && d_above) begin
      verdict_nxt = VERDICT_DEGEN;
    end else if (turn_same_i) begin
      verdict_nxt = VERDICT_CROSS;
    end else begin
      verdict_nxt = VERDICT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
  end

  assign strobe_o  = strobe_r;
  assign verdict_o = verdict_r;

endmodule

`default_nettype wire

// ----- hw/rtl/segment_intersection_classifier_top.sv -----
// Top level of the segment intersection classifier: epsilon register and the stage chain.
// A transaction taken at start reaches out_strobe after passing every register stage.
// Throughput: one transaction per cycle through four register stages (differences,
// products, sums, compares); busy stays low and results are never held back.
// Reset: synchronous active-low rst_n clears all valid bits and sets epsilon to 1.
`default_nettype none

module segment_intersection_classifier_top import sic_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] in_a_x,
  input  wire logic signed [COORD_BITS-1:0] in_a_y,
  input  wire logic signed [COORD_BITS-1:0] in_b_x,
  input  wire logic signed [COORD_BITS-1:0] in_b_y,
  input  wire logic signed [COORD_BITS-1:0] in_c_x,
  input  wire logic signed [COORD_BITS-1:0] in_c_y,
  input  wire logic signed [COORD_BITS-1:0] in_d_x,
  input  wire logic signed [COORD_BITS-1:0] in_d_y,
  output logic                              out_strobe,
  output logic             [1:0]            out_verdict,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic        [EPS_BITS-1:0]   cfg_data
);

  localparam int WW = wide_bits(COORD_BITS);

  logic [EPS_BITS-1:0]                eps_r, eps_nxt;
  sic_ctl_t                           ctl_d, ctl_m, ctl_s;
  logic signed [COORD_BITS:0]         diff [NDIFF];
  logic signed [2*COORD_BITS+1:0]     prod [NPROD];
  logic                               turn_same;
  logic signed [WW-1:0]               abac, abad, crc, crd, upper;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_comb begin
    eps_nxt = eps_r;
    if (cfg_valid && cfg_ready) begin
      eps_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else begin
      eps_r <= eps_nxt;
    end
  end

  sic_diff_stage #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk    (clk),
    .rst_n  (rst_n),
    .take_i (start && !busy),
    .a_x_i  (in_a_x),
    .a_y_i  (in_a_y),
    .b_x_i  (in_b_x),
    .b_y_i  (in_b_y),
    .c_x_i  (in_c_x),
    .c_y_i  (in_c_y),
    .d_x_i  (in_d_x),
    .d_y_i  (in_d_y),
    .ctl_o  (ctl_d),
    .diff_o (diff)
  );

  sic_mult_stage #(.COORD_BITS(COORD_BITS)) u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_d),
    .diff_i (diff),
    .ctl_o  (ctl_m),
    .prod_o (prod)
  );

  sic_sum_stage #(.COORD_BITS(COORD_BITS)) u_sum (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_i       (ctl_m),
    .prod_i      (prod),
    .eps_i       (eps_r),
    .ctl_o       (ctl_s),
    .turn_same_o (turn_same),
    .abac_o      (abac),
    .abad_o      (abad),
    .crc_o       (crc),
    .crd_o       (crd),
    .upper_o     (upper)
  );

  sic_decide_stage #(.COORD_BITS(COORD_BITS)) u_decide (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_i       (ctl_s),
    .turn_same_i (turn_same),
    .abac_i      (abac),
    .abad_i      (abad),
    .crc_i       (crc),
    .crd_i       (crd),
    .upper_i     (upper),
    .eps_i       (eps_r),
    .strobe_o    (out_strobe),
    .verdict_o   (out_verdict)
  );

  // Every accepted transaction gives exactly one result on out_strobe.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##4 out_strobe)
    else $error("accepted transaction produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, 4))
    else $error("result without an accepted transaction");

  // A shared endpoint always wins over the other tests.
  a_shared_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    (start && in_a_x == in_c_x && in_a_y == in_c_y) |-> ##4
      (out_verdict == VERDICT_DEGEN))
    else $error("shared endpoint not reported as degenerate");

endmodule

`default_nettype wire
